// ===== rtl/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every edge out of reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// consequent must hold in the same cycle as the antecedent
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/rclt_pkg.sv =====
// ----------------------------------------------------------------------------
// rclt_pkg
// Types and constants for the relay channel lockout timer: command and
// status codes, configuration register indexes, reset values and fixed field widths.
// ----------------------------------------------------------------------------
package rclt_pkg;

  // fixed field widths
  localparam int CMD_W      = 3;
  localparam int CHAN_W     = 4;
  localparam int STATUS_W   = 2;
  localparam int MASK_W     = 4;
  localparam int MIN_OFF_W  = 16;
  localparam int MAX_ON_W   = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // register reset values
  localparam logic [MIN_OFF_W-1:0] MIN_OFF_RESET    = 16'd3000;
  localparam logic [MAX_ON_W-1:0]  MAX_ON_RESET     = '0;
  localparam logic                 ACTIVE_LOW_RESET = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_OFF    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ON     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW = 2'd2;

  // command codes, the remaining codes are unknown commands
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 3'd0,
    CMD_ON      = 3'd1,
    CMD_OFF     = 3'd2,
    CMD_ALL_ON  = 3'd3,
    CMD_ALL_OFF = 3'd4
  } cmd_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 2'd0,
    ST_BUSY        = 2'd1,
    ST_BAD_CHANNEL = 2'd2,
    ST_BAD_CMD     = 2'd3
  } status_t;

endpackage

// ===== rtl/relay_channel_lockout_timer.sv =====
// ----------------------------------------------------------------------------
// relay_channel_lockout_timer: min-off / max-on protection for relay outputs
// Result: each accepted item's result is registered directly in the output register.
// Throughput: one item per cycle while the output is not stalled, per-channel counters and compares in parallel.
// Reset: relays off, counters saturated, registers at their reset values.
// ----------------------------------------------------------------------------
module relay_channel_lockout_timer
  import rclt_pkg::*;
#(
  parameter int NUM_CHANNELS = 4,
  parameter int COUNT_WIDTH  = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CMD_W-1:0]      cmd,
  input  logic [CHAN_W-1:0]     channel,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [STATUS_W-1:0]   status,
  output logic [MASK_W-1:0]     relay_states,
  output logic [MASK_W-1:0]     pin_levels,
  output logic [MASK_W-1:0]     auto_off_mask
);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam int CMP_W = (COUNT_WIDTH > MAX_ON_W) ? COUNT_WIDTH : MAX_ON_W;
  localparam int PAD_W = (NUM_CHANNELS > MASK_W) ? NUM_CHANNELS : MASK_W;

  // configuration registers
  logic [MIN_OFF_W-1:0] min_off_ms;
  logic [MAX_ON_W-1:0]  max_on_ms;
  logic                 active_low;

  // channel state
  logic [NUM_CHANNELS-1:0] relay_on;
  logic [NUM_CHANNELS-1:0] relay_on_next;
  logic [COUNT_WIDTH-1:0]  elapsed [NUM_CHANNELS];
  logic [COUNT_WIDTH-1:0]  elapsed_next [NUM_CHANNELS];

  // per-channel decode
  logic [COUNT_WIDTH-1:0]  count_inc [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] ch_sel;
  logic [NUM_CHANNELS-1:0] lockout;
  logic [NUM_CHANNELS-1:0] max_hit;
  logic                    ch_ok;

  // result values
  status_t                 status_next;
  logic [NUM_CHANNELS-1:0] auto_off;
  logic [NUM_CHANNELS-1:0] pins;
  logic [PAD_W-1:0]        states_pad;
  logic [PAD_W-1:0]        pins_pad;
  logic [PAD_W-1:0]        auto_pad;

  logic in_accept;

  // output register frees the input side whenever it can be emptied
  assign in_stall  = rst | (out_valid & out_stall);
  assign in_accept = in_valid & ~in_stall;

  // configuration writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      min_off_ms <= MIN_OFF_RESET;
      max_on_ms  <= MAX_ON_RESET;
      active_low <= ACTIVE_LOW_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_OFF:    min_off_ms <= cfg_data[MIN_OFF_W-1:0];
        CFG_MAX_ON:     max_on_ms  <= cfg_data[MAX_ON_W-1:0];
        CFG_ACTIVE_LOW: active_low <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // per-channel counters and compares
  assign ch_ok = (channel != '0) && (channel <= CHAN_W'(NUM_CHANNELS));

  always_comb begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      count_inc[i] = (elapsed[i] == COUNT_MAX) ? elapsed[i]
                                                : elapsed[i] + COUNT_WIDTH'(1);
      ch_sel[i]    = (channel == CHAN_W'(i + 1));
      lockout[i]   = ~relay_on[i] && (min_off_ms != '0) &&
                     (elapsed[i] < COUNT_WIDTH'(min_off_ms));
      max_hit[i]   = relay_on[i] && (max_on_ms != '0) &&
                     (CMP_W'(count_inc[i]) >= CMP_W'(max_on_ms));
    end
  end

  // next channel state and status for the current item
  always_comb begin
    relay_on_next = relay_on;
    elapsed_next  = elapsed;
    auto_off      = '0;
    status_next   = ST_OK;
    case (cmd_t'(cmd))
      CMD_TICK: begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          elapsed_next[i] = count_inc[i];
          if (max_hit[i]) begin
            relay_on_next[i] = 1'b0;
            elapsed_next[i]  = '0;
            auto_off[i]      = 1'b1;
          end
        end
      end
      CMD_ALL_ON: begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          if (!relay_on[i]) begin
            relay_on_next[i] = 1'b1;
            elapsed_next[i]  = '0;
          end
        end
      end
      CMD_ALL_OFF: begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          if (relay_on[i]) begin
            relay_on_next[i] = 1'b0;
            elapsed_next[i]  = '0;
          end
        end
      end
      CMD_ON: begin
        if (!ch_ok) begin
          status_next = ST_BAD_CHANNEL;
        end else begin
          for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (ch_sel[i] && lockout[i]) begin
              status_next = ST_BUSY;
            end else if (ch_sel[i] && !relay_on[i]) begin
              relay_on_next[i] = 1'b1;
              elapsed_next[i]  = '0;
            end
          end
        end
      end
      CMD_OFF: begin
        if (!ch_ok) begin
          status_next = ST_BAD_CHANNEL;
        end else begin
          for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (ch_sel[i] && relay_on[i]) begin
              relay_on_next[i] = 1'b0;
              elapsed_next[i]  = '0;
            end
          end
        end
      end
      default: begin
        status_next = ch_ok ? ST_BAD_CMD : ST_BAD_CHANNEL;
      end
    endcase
  end

  // pin polarity and padding to the fixed mask width
  assign pins       = active_low ? ~relay_on_next : relay_on_next;
  assign states_pad = PAD_W'(relay_on_next);
  assign pins_pad   = PAD_W'(pins);
  assign auto_pad   = PAD_W'(auto_off);

  // channel state update
  always_ff @(posedge clk) begin
    if (rst) begin
      relay_on <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        elapsed[i] <= COUNT_MAX;
      end
    end else if (in_accept) begin
      relay_on <= relay_on_next;
      elapsed  <= elapsed_next;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      status        <= status_next;
      relay_states  <= states_pad[MASK_W-1:0];
      pin_levels    <= pins_pad[MASK_W-1:0];
      auto_off_mask <= auto_pad[MASK_W-1:0];
    end
  end

endmodule

// ===== rtl/rclt_checker.sv =====
// ----------------------------------------------------------------------------
// rclt_checker
// Port-level checks on the relay channel lockout timer, bound into each instance of it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rclt_checker
  import rclt_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic [CMD_W-1:0]    cmd,
  input logic                out_valid,
  input logic                out_stall,
  input logic [STATUS_W-1:0] status,
  input logic [MASK_W-1:0]   relay_states,
  input logic [MASK_W-1:0]   auto_off_mask
);

  logic in_acc;
  logic tick_acc;
  logic all_off_acc;
  logic tick_ok;
  logic all_off_ok;

  // accepted items of interest and the results they must give
  assign in_acc      = in_valid & ~in_stall;
  assign tick_acc    = in_acc && (cmd == CMD_TICK);
  assign all_off_acc = in_acc && (cmd == CMD_ALL_OFF);
  assign tick_ok     = out_valid && (status == ST_OK);
  assign all_off_ok  = (relay_states == '0) && (auto_off_mask == '0);

  // a stalled result stays presented
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)

  // an empty output register never holds back the input
  `ASSERT_SAME(a_no_idle_stall, clk, rst, !out_valid, !in_stall)

  // a tick always yields an ok result in the next cycle
  `ASSERT_NEXT(a_tick_ok, clk, rst, tick_acc, tick_ok)

  // all off leaves every relay off with no auto-off flag
  `ASSERT_NEXT(a_all_off, clk, rst, all_off_acc, all_off_ok)

  // a channel switched off by the max-on limit is reported off
  `ASSERT_ALWAYS(a_auto_off, clk, rst, !out_valid || ((auto_off_mask & relay_states) == '0))

endmodule

bind relay_channel_lockout_timer rclt_checker u_rclt_checker (.*);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: relay channel lockout timer testbench
// Drives tick and command items through the valid/stall input channel,
// predicts every result with a cycle-free model of the relay bits and the
// per-channel elapsed counters, and checks each result on the output
// channel. Register settings change between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
  import rclt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_CH  = 4;
  localparam int COUNT_W = 24;
  localparam int RANDOM_ITEMS = 650;
  localparam int RANDOM_PHASES = 7;

  // command codes that the block does not know
  localparam logic [CMD_W-1:0] CMD_UNKNOWN_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNKNOWN_LAST  = 3'd7;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [CHAN_W-1:0] channel;
  } relay_item_t;

  typedef struct packed {
    status_t           status;
    logic [MASK_W-1:0] relay_states;
    logic [MASK_W-1:0] pin_levels;
    logic [MASK_W-1:0] auto_off_mask;
  } relay_result_t;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  // relay state predictor and store of expected results
  class relay_scoreboard;
    logic [MIN_OFF_W-1:0] min_off;
    logic [MAX_ON_W-1:0]  max_on;
    logic                 active_low;
    logic [NUM_CH-1:0]    relay_on;
    logic [COUNT_W-1:0]   elapsed [NUM_CH];
    relay_result_t        pending_results [$];
    int                   items_noted;
    int                   results_checked;
    int                   failures;
    int                   status_seen [4];
    int                   auto_off_ticks;

    function new();
      min_off    = MIN_OFF_RESET;
      max_on     = MAX_ON_RESET;
      active_low = ACTIVE_LOW_RESET;
      relay_on   = '0;
      foreach (elapsed[i]) elapsed[i] = '1;
      items_noted     = 0;
      results_checked = 0;
      failures        = 0;
      auto_off_ticks  = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_MIN_OFF:    min_off = data[MIN_OFF_W-1:0];
        CFG_MAX_ON:     max_on = data[MAX_ON_W-1:0];
        CFG_ACTIVE_LOW: active_low = data[0];
        default: ;
      endcase
    endfunction

    // count restarts only when the relay really changes state
    function void switch_relay(int idx, logic on);
      if (relay_on[idx] != on) begin
        relay_on[idx] = on;
        elapsed[idx]  = '0;
      end
    endfunction

    function relay_result_t predict_step(logic [CMD_W-1:0] c, logic [CHAN_W-1:0] ch);
      relay_result_t r;
      int idx;
      r = '0;
      r.status = ST_OK;
      if (c == CMD_TICK) begin
        // count up with saturation, then apply the max-on limit
        for (int i = 0; i < NUM_CH; i++) begin
          if (elapsed[i] != '1) elapsed[i] = elapsed[i] + 1'b1;
          if (relay_on[i] && max_on != 0 && elapsed[i] >= max_on) begin
            switch_relay(i, 1'b0);
            r.auto_off_mask[i] = 1'b1;
          end
        end
      end else if (c == CMD_ALL_ON || c == CMD_ALL_OFF) begin
        for (int i = 0; i < NUM_CH; i++) switch_relay(i, c == CMD_ALL_ON);
      end else if (ch == 0 || ch > NUM_CH) begin
        r.status = ST_BAD_CHANNEL;
      end else begin
        idx = ch - 1;
        if (c == CMD_ON) begin
          if (!relay_on[idx] && min_off != 0 && elapsed[idx] < min_off)
            r.status = ST_BUSY;
          else
            switch_relay(idx, 1'b1);
        end else if (c == CMD_OFF) begin
          switch_relay(idx, 1'b0);
        end else begin
          r.status = ST_BAD_CMD;
        end
      end
      r.relay_states = relay_on;
      r.pin_levels   = relay_on ^ {NUM_CH{active_low}};
      return r;
    endfunction

    function void note_item(logic [CMD_W-1:0] c, logic [CHAN_W-1:0] ch);
      pending_results.push_back(predict_step(c, ch));
      items_noted++;
    endfunction

    function void check_result(relay_result_t got);
      relay_result_t want;
      if (pending_results.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result: status %0d states %b pins %b auto_off %b",
                   got.status, got.relay_states, got.pin_levels, got.auto_off_mask);
        return;
      end
      want = pending_results.pop_front();
      results_checked++;
      status_seen[want.status]++;
      if (want.auto_off_mask != 0) auto_off_ticks++;
      if (got.status !== want.status || got.relay_states !== want.relay_states ||
          got.pin_levels !== want.pin_levels || got.auto_off_mask !== want.auto_off_mask) begin
        failures++;
        if (failures <= 10) begin
          $display("mismatch on result %0d: expected status %0d states %b pins %b auto_off %b",
                   results_checked, want.status, want.relay_states, want.pin_levels,
                   want.auto_off_mask);
          $display("  got status %0d states %b pins %b auto_off %b",
                   got.status, got.relay_states, got.pin_levels, got.auto_off_mask);
        end
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [CMD_W-1:0]      cmd;
  logic [CHAN_W-1:0]     channel;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [STATUS_W-1:0]   status;
  logic [MASK_W-1:0]     relay_states;
  logic [MASK_W-1:0]     pin_levels;
  logic [MASK_W-1:0]     auto_off_mask;

  relay_scoreboard sb;
  relay_item_t     item_queue [$];
  stall_mode_t     stall_mode = STALL_NONE;
  int              stall_left = 0;
  int              settings_used = 0;

  relay_channel_lockout_timer #(
    .NUM_CHANNELS(NUM_CH),
    .COUNT_WIDTH (COUNT_W)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .channel      (channel),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .relay_states (relay_states),
    .pin_levels   (pin_levels),
    .auto_off_mask(auto_off_mask)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver stall pattern, mode redrawn at random whenever its countdown runs out
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(20, 150);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= (stall_left[1:0] == 2'b00);
    endcase
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result('{status_t'(status), relay_states, pin_levels, auto_off_mask});
  end

  // send queued items in bursts with random gaps
  task automatic send_queue();
    relay_item_t it;
    int burst;
    int gap;
    while (item_queue.size() != 0) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && item_queue.size() != 0) begin
        it = item_queue.pop_front();
        in_valid <= 1'b1;
        cmd      <= it.cmd;
        channel  <= it.channel;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_item(it.cmd, it.channel);
        burst--;
      end
      if (item_queue.size() == 0) gap = 1;
      else if ($urandom_range(0, 2) == 0) gap = 0;
      else gap = $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic queue_item(logic [CMD_W-1:0] c, logic [CHAN_W-1:0] ch);
    item_queue.push_back('{c, ch});
  endtask

  // mostly ticks and valid on/off traffic, some bad channels and codes
  task automatic fill_random(int n);
    relay_item_t it;
    int roll;
    repeat (n) begin
      roll = $urandom_range(0, 99);
      if (roll < 45)      it.cmd = CMD_TICK;
      else if (roll < 65) it.cmd = CMD_ON;
      else if (roll < 80) it.cmd = CMD_OFF;
      else if (roll < 85) it.cmd = CMD_ALL_ON;
      else if (roll < 90) it.cmd = CMD_ALL_OFF;
      else it.cmd = CMD_W'($urandom_range(CMD_UNKNOWN_FIRST, CMD_UNKNOWN_LAST));
      if ($urandom_range(0, 6) == 0) it.channel = CHAN_W'($urandom_range(0, 15));
      else it.channel = CHAN_W'($urandom_range(1, NUM_CH));
      item_queue.push_back(it);
    end
  endtask

  // wait until idle, then write all three registers
  task automatic apply_config(logic [CFG_DATA_W-1:0] d_min_off, logic [CFG_DATA_W-1:0] d_max_on,
                              logic [CFG_DATA_W-1:0] d_active_low);
    logic [CFG_IDX_W-1:0]  regs [3];
    logic [CFG_DATA_W-1:0] vals [3];
    regs = '{CFG_MIN_OFF, CFG_MAX_ON, CFG_ACTIVE_LOW};
    vals = '{d_min_off, d_max_on, d_active_low};
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    for (int i = 0; i < 3; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      sb.set_register(regs[i], vals[i]);
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // main sequence
  initial begin
    sb        = new();
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    cmd       = CMD_TICK;
    channel   = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: saturated counters allow the first on, lockout after off
    settings_used = 1;
    queue_item(CMD_TICK, 4'd0);
    queue_item(CMD_ON, 4'd1);
    queue_item(CMD_ON, 4'd1);
    queue_item(CMD_OFF, 4'd1);
    queue_item(CMD_ON, 4'd1);
    queue_item(CMD_ON, 4'd0);
    queue_item(CMD_OFF, 4'd5);
    queue_item(CMD_ON, 4'd15);
    queue_item(CMD_UNKNOWN_FIRST, 4'd2);
    queue_item(CMD_UNKNOWN_LAST, 4'd0);
    queue_item(CMD_W'(CMD_UNKNOWN_FIRST + 1), 4'd4);
    queue_item(CMD_ALL_ON, 4'd9);
    queue_item(CMD_TICK, 4'd7);
    queue_item(CMD_OFF, 4'd3);
    queue_item(CMD_OFF, 4'd3);
    queue_item(CMD_ALL_OFF, 4'd12);
    queue_item(CMD_ON, 4'd4);
    send_queue();

    // lockout and max-on boundaries at two milliseconds, active-high pins
    apply_config(24'd2, 24'd2, 24'd0);
    queue_item(CMD_TICK, 4'd2);
    queue_item(CMD_ON, 4'd2);
    queue_item(CMD_TICK, 4'd8);
    queue_item(CMD_ON, 4'd2);
    queue_item(CMD_TICK, 4'd0);
    queue_item(CMD_TICK, 4'd0);
    queue_item(CMD_ALL_ON, 4'd0);
    queue_item(CMD_TICK, 4'd15);
    queue_item(CMD_TICK, 4'd1);
    send_queue();

    // random phases over a spread of settings
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: apply_config(24'd0, 24'd0, 24'd1);
        1: apply_config(24'd65535, 24'hFFFFFF, 24'd0);
        2: apply_config(24'd1, 24'd1, 24'd1);
        3: apply_config(CFG_DATA_W'($urandom_range(1, 12)),
                        CFG_DATA_W'($urandom_range(1, 16)),
                        CFG_DATA_W'($urandom_range(0, 1)));
        4: apply_config(CFG_DATA_W'($urandom_range(3, 30)),
                        CFG_DATA_W'($urandom_range(5, 40)),
                        CFG_DATA_W'($urandom_range(0, 1)));
        5: apply_config(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
        default: apply_config(24'(MIN_OFF_RESET), 24'(MAX_ON_RESET), 24'(ACTIVE_LOW_RESET));
      endcase
      fill_random(RANDOM_ITEMS / RANDOM_PHASES);
      send_queue();
    end

    // drain and let the pipeline settle
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("run covered %0d items under %0d register settings, %0d results checked",
             sb.items_noted, settings_used, sb.results_checked);
    $display("ok %0d, busy %0d, bad channel %0d, bad command %0d, auto-off ticks %0d",
             sb.status_seen[ST_OK], sb.status_seen[ST_BUSY], sb.status_seen[ST_BAD_CHANNEL],
             sb.status_seen[ST_BAD_CMD], sb.auto_off_ticks);
    if (sb.failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
